@@ design/acs_pkg.sv @@
package acs_pkg;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [9:0]         mem_address;
      logic signed [31:0] mem_write_data;
      logic signed [31:0] io_read_data;
      logic               io_ok;
   } req_type;

   typedef struct packed {
      logic [2:0]         error_code;
      logic signed [31:0] error_where;
      logic signed [31:0] pc_out;
      logic signed [31:0] acc_out;
      logic signed [31:0] index_out;
      logic signed [31:0] stack_ptr_out;
      logic signed [31:0] mem_read_data;
      logic [1:0]         io_access;
      logic signed [31:0] io_device;
      logic signed [31:0] io_write_data;
   } rsp_type;

   // controller to datapath: one step strobe per controller state
   typedef struct packed {
      logic accept;
      logic mem_write;
      logic mem_read;
      logic fetch;
      logic decode;
      logic arg;
      logic exec;
      logic div_wb;
      logic finish;
   } ctl_type;

   typedef struct packed {
      logic frozen;
      logic fault;
      logic need_arg;
      logic need_div;
      logic div_done;
   } stat_type;

   localparam logic [1:0] CMD_EXEC  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam logic [1:0] CMD_NONE  = 2'd3;

   localparam logic [2:0] ERR_NONE   = 3'd0;
   localparam logic [2:0] ERR_HALT   = 3'd1;
   localparam logic [2:0] ERR_OPCODE = 3'd2;
   localparam logic [2:0] ERR_ADDR   = 3'd3;
   localparam logic [2:0] ERR_IO     = 3'd4;
   localparam logic [2:0] ERR_STACK  = 3'd5;

   localparam logic [1:0] FLAG_NONE    = 2'd0;
   localparam logic [1:0] FLAG_LESS    = 2'd1;
   localparam logic [1:0] FLAG_EQUAL   = 2'd2;
   localparam logic [1:0] FLAG_GREATER = 2'd3;

   localparam logic [1:0] IO_NONE  = 2'd0;
   localparam logic [1:0] IO_READ  = 2'd1;
   localparam logic [1:0] IO_WRITE = 2'd2;

   localparam logic [10:0] STACK_BASE_RESET = 11'd512;

   localparam logic [4:0] OP_NOP   = 5'd0;
   localparam logic [4:0] OP_HALT  = 5'd1;
   localparam logic [4:0] OP_LDI   = 5'd2;
   localparam logic [4:0] OP_LDD   = 5'd3;
   localparam logic [4:0] OP_LDX   = 5'd4;
   localparam logic [4:0] OP_STD   = 5'd5;
   localparam logic [4:0] OP_STX   = 5'd6;
   localparam logic [4:0] OP_TAX   = 5'd7;
   localparam logic [4:0] OP_TXA   = 5'd8;
   localparam logic [4:0] OP_INX   = 5'd9;
   localparam logic [4:0] OP_ADD   = 5'd10;
   localparam logic [4:0] OP_SUB   = 5'd11;
   localparam logic [4:0] OP_MUL   = 5'd12;
   localparam logic [4:0] OP_DIV   = 5'd13;
   localparam logic [4:0] OP_REM   = 5'd14;
   localparam logic [4:0] OP_NEG   = 5'd15;
   localparam logic [4:0] OP_JMP   = 5'd16;
   localparam logic [4:0] OP_JZ    = 5'd17;
   localparam logic [4:0] OP_JNZ   = 5'd18;
   localparam logic [4:0] OP_IN    = 5'd19;
   localparam logic [4:0] OP_OUT   = 5'd20;
   localparam logic [4:0] OP_CMP   = 5'd21;
   localparam logic [4:0] OP_JGT   = 5'd22;
   localparam logic [4:0] OP_JLT   = 5'd23;
   localparam logic [4:0] OP_JEQ   = 5'd24;
   localparam logic [4:0] OP_PUSHA = 5'd25;
   localparam logic [4:0] OP_POPA  = 5'd26;
   localparam logic [4:0] OP_PUSHX = 5'd27;
   localparam logic [4:0] OP_POPX  = 5'd28;
   localparam logic [4:0] OP_BAD   = 5'd31;
   localparam logic [31:0] OP_COUNT = 32'd29;

endpackage

@@ design/acs_div.sv @@
module acs_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient,
   output logic [31:0] remainder
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  count_ff, count_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic        neg_q_ff, neg_q_in;
   logic        neg_r_ff, neg_r_in;
   logic [32:0] rem_shift;
   logic        fits;

   assign rem_shift = {rem_ff[31:0], quo_ff[31]};
   assign fits      = rem_shift >= {1'b0, dvs_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = 5'd0;
         rem_in   = 33'd0;
         quo_in   = dividend[31] ? 32'd0 - dividend : dividend;
         dvs_in   = divisor[31] ? 32'd0 - divisor : divisor;
         neg_q_in = dividend[31] ^ divisor[31];
         neg_r_in = dividend[31];
      end else if (busy_ff) begin
         // one quotient bit per cycle, restoring
         rem_in   = fits ? rem_shift - {1'b0, dvs_ff} : rem_shift;
         quo_in   = {quo_ff[30:0], fits};
         count_in = count_ff + 5'd1;
         if (count_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dvs_ff   <= dvs_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
   end

   assign done      = done_ff;
   assign quotient  = neg_q_ff ? 32'd0 - quo_ff : quo_ff;
   assign remainder = neg_r_ff ? 32'd0 - rem_ff[31:0] : rem_ff[31:0];

endmodule

@@ design/acs_dpath.sv @@
module acs_dpath #(
   parameter int MEM_WORDS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  acs_pkg::ctl_type  ctl,
   output acs_pkg::stat_type stat,
   input  acs_pkg::req_type  req_word,
   input  logic              csr_write_enable,
   input  logic [10:0]       csr_write_data,
   output acs_pkg::rsp_type  rsp_word
);

   localparam int AW = $clog2(MEM_WORDS);
   localparam logic [31:0] MEM_LIMIT = 32'(MEM_WORDS);

   logic [31:0] mem [MEM_WORDS];
   logic [31:0] mem_q;
   logic        mem_we, mem_re;
   logic [31:0] mem_wa, mem_ra, mem_wd;

   acs_pkg::req_type req_ff, req_in;
   acs_pkg::rsp_type rsp_ff, rsp_in;
   logic [31:0] pc_ff, pc_in, acc_ff, acc_in, x_ff, x_in, sp_ff, sp_in;
   logic [1:0]  flag_ff, flag_in;
   logic [2:0]  err_ff, err_in;
   logic [31:0] where_ff, where_in;
   logic [10:0] base_ff, base_in;
   logic [4:0]  op_ff, op_in;
   logic [31:0] arg_ff, arg_in;
   logic [1:0]  io_acc_ff, io_acc_in;
   logic [31:0] io_dev_ff, io_dev_in, io_wd_ff, io_wd_in;

   logic [4:0]  op_now;
   logic [31:0] pc_plus1, opr_addr, st_addr, sp_minus1, cmd_addr;
   logic        pop_ok;
   logic        div_start, div_done;
   logic [31:0] div_quo, div_rem;

   function automatic logic in_mem(input logic [31:0] a);
      return a < MEM_LIMIT;
   endfunction

   function automatic logic taken(input logic [4:0] op, input logic [31:0] acc,
                                  input logic [1:0] flag);
      logic t;
      t = 1'b0;
      case (op)
         acs_pkg::OP_JMP: t = 1'b1;
         acs_pkg::OP_JZ:  t = acc == 32'd0;
         acs_pkg::OP_JNZ: t = acc != 32'd0;
         acs_pkg::OP_JGT: t = flag == acs_pkg::FLAG_GREATER;
         acs_pkg::OP_JLT: t = flag == acs_pkg::FLAG_LESS;
         acs_pkg::OP_JEQ: t = flag == acs_pkg::FLAG_EQUAL;
         default:         t = 1'b0;
      endcase
      return t;
   endfunction

   function automatic logic needs_opr(input logic [4:0] op);
      logic n;
      case (op)
         acs_pkg::OP_LDD, acs_pkg::OP_LDX, acs_pkg::OP_ADD, acs_pkg::OP_SUB,
         acs_pkg::OP_MUL, acs_pkg::OP_DIV, acs_pkg::OP_REM, acs_pkg::OP_CMP: n = 1'b1;
         default: n = 1'b0;
      endcase
      return n;
   endfunction

   function automatic logic needs_arg(input logic [4:0] op, input logic [31:0] acc,
                                      input logic [1:0] flag);
      logic n;
      case (op)
         acs_pkg::OP_LDI, acs_pkg::OP_STD, acs_pkg::OP_STX, acs_pkg::OP_IN,
         acs_pkg::OP_OUT: n = 1'b1;
         default: n = needs_opr(op) || taken(op, acc, flag);
      endcase
      return n;
   endfunction

   assign op_now    = (mem_q < acs_pkg::OP_COUNT) ? mem_q[4:0] : acs_pkg::OP_BAD;
   assign pc_plus1  = pc_ff + 32'd1;
   assign sp_minus1 = sp_ff - 32'd1;
   assign opr_addr  = (op_ff == acs_pkg::OP_LDX) ? mem_q + x_ff : mem_q;
   assign st_addr   = (op_ff == acs_pkg::OP_STX) ? arg_ff + x_ff : arg_ff;
   assign cmd_addr  = {22'd0, req_ff.mem_address};
   assign pop_ok    = !sp_ff[31] && (sp_ff > {21'd0, base_ff}) && in_mem(sp_minus1);

   always_comb begin
      req_in    = req_ff;
      rsp_in    = rsp_ff;
      pc_in     = pc_ff;
      acc_in    = acc_ff;
      x_in      = x_ff;
      sp_in     = sp_ff;
      flag_in   = flag_ff;
      err_in    = err_ff;
      where_in  = where_ff;
      base_in   = base_ff;
      op_in     = op_ff;
      arg_in    = arg_ff;
      io_acc_in = io_acc_ff;
      io_dev_in = io_dev_ff;
      io_wd_in  = io_wd_ff;
      mem_we    = 1'b0;
      mem_wa    = 32'd0;
      mem_wd    = 32'd0;
      mem_re    = 1'b0;
      mem_ra    = 32'd0;
      div_start = 1'b0;
      stat      = '0;

      if (ctl.accept) begin
         req_in    = req_word;
         io_acc_in = acs_pkg::IO_NONE;
         io_dev_in = 32'd0;
         io_wd_in  = 32'd0;
      end

      if (ctl.mem_write && in_mem(cmd_addr)) begin
         mem_we = 1'b1;
         mem_wa = cmd_addr;
         mem_wd = req_ff.mem_write_data;
      end

      if (ctl.mem_read) begin
         mem_re = 1'b1;
         mem_ra = cmd_addr;
      end

      if (ctl.fetch) begin
         if (in_mem(pc_ff)) begin
            mem_re = 1'b1;
            mem_ra = pc_ff;
         end else begin
            stat.fault = 1'b1;
            err_in     = acs_pkg::ERR_ADDR;
            where_in   = pc_ff;
         end
      end

      if (ctl.decode) begin
         op_in = op_now;
         if (needs_arg(op_now, acc_ff, flag_ff)) begin
            stat.need_arg = 1'b1;
            if (in_mem(pc_plus1)) begin
               mem_re = 1'b1;
               mem_ra = pc_plus1;
            end else begin
               stat.fault = 1'b1;
               err_in     = acs_pkg::ERR_ADDR;
               where_in   = pc_plus1;
            end
         end else if ((op_now == acs_pkg::OP_POPA || op_now == acs_pkg::OP_POPX)
                      && pop_ok) begin
            mem_re = 1'b1;
            mem_ra = sp_minus1;
         end
      end

      if (ctl.arg) begin
         arg_in = mem_q;
         if (needs_opr(op_ff)) begin
            if (in_mem(opr_addr)) begin
               mem_re = 1'b1;
               mem_ra = opr_addr;
            end else begin
               stat.fault = 1'b1;
               err_in     = acs_pkg::ERR_ADDR;
               where_in   = opr_addr;
            end
         end
      end

      if (ctl.exec) begin
         case (op_ff)
            acs_pkg::OP_NOP: pc_in = pc_plus1;
            acs_pkg::OP_HALT: begin
               err_in   = acs_pkg::ERR_HALT;
               where_in = 32'd0;
            end
            acs_pkg::OP_LDI: begin
               acc_in = arg_ff;
               pc_in  = pc_ff + 32'd2;
            end
            acs_pkg::OP_LDD, acs_pkg::OP_LDX: begin
               acc_in = mem_q;
               pc_in  = pc_ff + 32'd2;
            end
            acs_pkg::OP_STD, acs_pkg::OP_STX: begin
               if (in_mem(st_addr)) begin
                  mem_we = 1'b1;
                  mem_wa = st_addr;
                  mem_wd = acc_ff;
                  pc_in  = pc_ff + 32'd2;
               end else begin
                  err_in   = acs_pkg::ERR_ADDR;
                  where_in = st_addr;
               end
            end
            acs_pkg::OP_TAX: begin
               x_in  = acc_ff;
               pc_in = pc_plus1;
            end
            acs_pkg::OP_TXA: begin
               acc_in = x_ff;
               pc_in  = pc_plus1;
            end
            acs_pkg::OP_INX: begin
               x_in  = x_ff + 32'd1;
               pc_in = pc_plus1;
            end
            acs_pkg::OP_ADD: begin
               acc_in = acc_ff + mem_q;
               pc_in  = pc_ff + 32'd2;
            end
            acs_pkg::OP_SUB: begin
               acc_in = acc_ff - mem_q;
               pc_in  = pc_ff + 32'd2;
            end
            acs_pkg::OP_MUL: begin
               acc_in = acc_ff * mem_q;
               pc_in  = pc_ff + 32'd2;
            end
            acs_pkg::OP_DIV, acs_pkg::OP_REM: begin
               if (mem_q == 32'd0) begin
                  // divide by zero: quotient all ones, remainder keeps the dividend
                  if (op_ff == acs_pkg::OP_DIV) acc_in = 32'hFFFF_FFFF;
                  pc_in = pc_ff + 32'd2;
               end else begin
                  div_start     = 1'b1;
                  stat.need_div = 1'b1;
               end
            end
            acs_pkg::OP_NEG: begin
               acc_in = 32'd0 - acc_ff;
               pc_in  = pc_plus1;
            end
            acs_pkg::OP_JMP, acs_pkg::OP_JZ, acs_pkg::OP_JNZ,
            acs_pkg::OP_JGT, acs_pkg::OP_JLT, acs_pkg::OP_JEQ: begin
               pc_in = taken(op_ff, acc_ff, flag_ff) ? arg_ff : pc_ff + 32'd2;
            end
            acs_pkg::OP_IN, acs_pkg::OP_OUT: begin
               if (req_ff.io_ok) begin
                  io_dev_in = arg_ff;
                  pc_in     = pc_ff + 32'd2;
                  if (op_ff == acs_pkg::OP_IN) begin
                     acc_in    = req_ff.io_read_data;
                     io_acc_in = acs_pkg::IO_READ;
                  end else begin
                     io_acc_in = acs_pkg::IO_WRITE;
                     io_wd_in  = acc_ff;
                  end
               end else begin
                  err_in   = acs_pkg::ERR_IO;
                  where_in = arg_ff;
               end
            end
            acs_pkg::OP_CMP: begin
               if ($signed(acc_ff) > $signed(mem_q)) flag_in = acs_pkg::FLAG_GREATER;
               else if ($signed(acc_ff) < $signed(mem_q)) flag_in = acs_pkg::FLAG_LESS;
               else flag_in = acs_pkg::FLAG_EQUAL;
               pc_in = pc_ff + 32'd2;
            end
            acs_pkg::OP_PUSHA, acs_pkg::OP_PUSHX: begin
               if (in_mem(sp_ff)) begin
                  mem_we = 1'b1;
                  mem_wa = sp_ff;
                  mem_wd = (op_ff == acs_pkg::OP_PUSHA) ? acc_ff : x_ff;
                  sp_in  = sp_ff + 32'd1;
                  pc_in  = pc_plus1;
               end else begin
                  err_in   = acs_pkg::ERR_STACK;
                  where_in = sp_ff;
               end
            end
            acs_pkg::OP_POPA, acs_pkg::OP_POPX: begin
               if (pop_ok) begin
                  if (op_ff == acs_pkg::OP_POPA) acc_in = mem_q;
                  else x_in = mem_q;
                  sp_in = sp_minus1;
                  pc_in = pc_plus1;
               end else begin
                  err_in   = acs_pkg::ERR_STACK;
                  where_in = sp_ff;
               end
            end
            default: begin
               err_in   = acs_pkg::ERR_OPCODE;
               where_in = 32'd0;
            end
         endcase
      end

      if (ctl.div_wb) begin
         acc_in = (op_ff == acs_pkg::OP_DIV) ? div_quo : div_rem;
         pc_in  = pc_ff + 32'd2;
      end

      if (ctl.finish) begin
         rsp_in.error_code    = err_ff;
         rsp_in.error_where   = where_ff;
         rsp_in.pc_out        = pc_ff;
         rsp_in.acc_out       = acc_ff;
         rsp_in.index_out     = x_ff;
         rsp_in.stack_ptr_out = sp_ff;
         rsp_in.mem_read_data = (req_ff.cmd == acs_pkg::CMD_READ && in_mem(cmd_addr))
                                ? mem_q : 32'd0;
         rsp_in.io_access     = io_acc_ff;
         rsp_in.io_device     = io_dev_ff;
         rsp_in.io_write_data = io_wd_ff;
      end

      // stack base write also reloads the stack pointer
      if (csr_write_enable) begin
         base_in = csr_write_data;
         sp_in   = {21'd0, csr_write_data};
      end

      stat.frozen   = err_ff != acs_pkg::ERR_NONE;
      stat.div_done = div_done;
   end

   acs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (acc_ff),
      .divisor   (mem_q),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa[AW-1:0]] <= mem_wd;
      if (mem_re) mem_q <= mem[mem_ra[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff    <= 32'd0;
         acc_ff   <= 32'd0;
         x_ff     <= 32'd0;
         sp_ff    <= {21'd0, acs_pkg::STACK_BASE_RESET};
         flag_ff  <= acs_pkg::FLAG_NONE;
         err_ff   <= acs_pkg::ERR_NONE;
         where_ff <= 32'd0;
         base_ff  <= acs_pkg::STACK_BASE_RESET;
      end else begin
         pc_ff    <= pc_in;
         acc_ff   <= acc_in;
         x_ff     <= x_in;
         sp_ff    <= sp_in;
         flag_ff  <= flag_in;
         err_ff   <= err_in;
         where_ff <= where_in;
         base_ff  <= base_in;
      end
      req_ff    <= req_in;
      rsp_ff    <= rsp_in;
      op_ff     <= op_in;
      arg_ff    <= arg_in;
      io_acc_ff <= io_acc_in;
      io_dev_ff <= io_dev_in;
      io_wd_ff  <= io_wd_in;
   end

   assign rsp_word = rsp_ff;

endmodule

@@ design/acs_ctrl.sv @@
module acs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [1:0]        req_cmd,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  acs_pkg::stat_type stat,
   output acs_pkg::ctl_type  ctl
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MEMW = 4'd1;
   localparam logic [3:0] S_MEMR = 4'd2;
   localparam logic [3:0] S_OP   = 4'd3;
   localparam logic [3:0] S_DEC  = 4'd4;
   localparam logic [3:0] S_ARG  = 4'd5;
   localparam logic [3:0] S_EXEC = 4'd6;
   localparam logic [3:0] S_DIV  = 4'd7;
   localparam logic [3:0] S_FIN  = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in   = state_ff;
      ctl        = '0;
      ctl.accept = (state_ff == S_IDLE) && req_valid;
      ctl.finish = (state_ff == S_FIN) && (!rsp_valid_ff || !rsp_stall);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_cmd)
                  acs_pkg::CMD_EXEC:  state_in = stat.frozen ? S_FIN : S_OP;
                  acs_pkg::CMD_WRITE: state_in = S_MEMW;
                  acs_pkg::CMD_READ:  state_in = S_MEMR;
                  default:            state_in = S_FIN;
               endcase
            end
         end
         S_MEMW: begin
            ctl.mem_write = 1'b1;
            state_in      = S_FIN;
         end
         S_MEMR: begin
            ctl.mem_read = 1'b1;
            state_in     = S_FIN;
         end
         S_OP: begin
            ctl.fetch = 1'b1;
            state_in  = stat.fault ? S_FIN : S_DEC;
         end
         S_DEC: begin
            ctl.decode = 1'b1;
            if (stat.fault) state_in = S_FIN;
            else state_in = stat.need_arg ? S_ARG : S_EXEC;
         end
         S_ARG: begin
            ctl.arg  = 1'b1;
            state_in = stat.fault ? S_FIN : S_EXEC;
         end
         S_EXEC: begin
            ctl.exec = 1'b1;
            state_in = stat.need_div ? S_DIV : S_FIN;
         end
         S_DIV: begin
            ctl.div_wb = stat.div_done;
            if (stat.div_done) state_in = S_FIN;
         end
         S_FIN: begin
            if (ctl.finish) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      // hold the word until taken, reload on finish
      rsp_valid_in = ctl.finish || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      ctl.finish |=> rsp_valid_ff)
      else $error("finished word not presented");

   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.mem_write, ctl.mem_read, ctl.fetch, ctl.decode, ctl.arg, ctl.exec,
                ctl.div_wb}))
      else $error("more than one datapath step at once");

   a_frozen_skip: assert property (@(posedge clock) disable iff (reset)
      (ctl.accept && req_cmd == acs_pkg::CMD_EXEC && stat.frozen) |=> state_ff == S_FIN)
      else $error("execute ran with sticky error set");

   a_exec_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && !stat.need_div) |=> state_ff == S_FIN)
      else $error("execute did not finish");

endmodule

@@ design/accumulator_cpu_step_unit.sv @@
// Accumulator machine step unit with a private word memory of MEM_WORDS words.
// Each request word carries one command: execute one instruction, write a memory
// word or read a memory word; each gives exactly one response word holding the
// sticky error, the registers and any I/O access. Commands run one at a time
// through a state machine over a single-port memory with registered read data.
// A memory write or read goes through its access state to the response, and a
// no-op straight to it. An instruction walks: fetch opcode, fetch argument, fetch
// operand, execute, respond; one without an argument or operand still walks the
// same path minus the skipped read states. Divide and remainder wait for the
// one-bit-per-cycle divider. The response register lets the next request
// be accepted while the previous response is still stalled. Stack base writes
// also reload the stack pointer and must be made while the unit is idle.
module accumulator_cpu_step_unit #(
   parameter int MEM_WORDS = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  acs_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output acs_pkg::rsp_type rsp_word,
   input  logic             csr_write_enable,
   input  logic [10:0]      csr_write_data
);

   acs_pkg::ctl_type  ctl;
   acs_pkg::stat_type stat;

   acs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_word.cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .ctl       (ctl)
   );

   acs_dpath #(
      .MEM_WORDS (MEM_WORDS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .stat             (stat),
      .req_word         (req_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_word         (rsp_word)
   );

endmodule
